// ===== rtl/sitda_pkg.sv =====
// ----------------------------------------------------------------------------
// sitda_pkg: shared types and constants for the integer to decimal text core
// Holds the controller state type, the character codes and the bcd adjust step.
// ----------------------------------------------------------------------------
package sitda_pkg;

    localparam int unsigned VALUE_W    = 32;
    localparam int unsigned NUM_DIGITS = 10;
    localparam int unsigned BCD_W      = 4 * NUM_DIGITS;
    localparam int unsigned BITCNT_W   = $clog2(VALUE_W);
    localparam int unsigned DIGCNT_W   = $clog2(NUM_DIGITS + 1);

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_EMIT
    } t_state;

    // add 3 to every bcd digit that is 5 or more, ahead of the next shift
    function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] bcd);
        logic [BCD_W-1:0] res;
        res = bcd;
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (bcd[4*d +: 4] >= 4'd5) begin
                res[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
            end
        end
        return res;
    endfunction

endpackage

// ===== rtl/signed_int_to_decimal_ascii_core.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core: signed 32-bit integer to decimal ascii
// Bit-serial double dabble conversion, then one character per transfer.
// ----------------------------------------------------------------------------
// Sequence: one item at a time; an item is accepted in idle, converted by a
// shift-add-3 step for each of the 32 input bits, then its leading zero digits
// are skipped (one digit is always kept), a minus sign goes out for a negative
// value and the digit characters follow; sign and digits wait on a stalled output.
// Reset: synchronous active low; returns to idle with no character pending.
module signed_int_to_decimal_ascii_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [sitda_pkg::VALUE_W-1:0]   i_value,
    input  logic                            i_valid,
    output logic                            o_ready,
    output logic [7:0]                      o_character,
    output logic                            o_last,
    output logic                            o_valid,
    input  logic                            i_ready
);
    import sitda_pkg::*;

    t_state                 r_state, n_state;
    logic [VALUE_W-1:0]     r_bin, n_bin;
    logic [BCD_W-1:0]       r_bcd, n_bcd;
    logic [BITCNT_W-1:0]    r_cnt, n_cnt;
    logic [DIGCNT_W-1:0]    r_ndig, n_ndig;
    logic                   r_neg, n_neg;
    logic                   r_valid, n_valid;
    logic [7:0]             r_char, n_char;
    logic                   r_last, n_last;

    logic                   in_xfer;
    logic                   slot_free;
    logic                   top_zero;
    logic [BCD_W-1:0]       bcd_adj;

    assign in_xfer   = i_valid && (r_state == ST_IDLE);
    assign slot_free = !r_valid || i_ready;
    assign top_zero  = (r_bcd[BCD_W-1 -: 4] == 4'd0);
    assign bcd_adj   = bcd_adjust(r_bcd);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) n_state = ST_CONV;
            end
            ST_CONV: begin
                if (r_cnt == BITCNT_W'(VALUE_W - 1)) n_state = ST_SKIP;
            end
            ST_SKIP: begin
                if (!(top_zero && r_ndig > DIGCNT_W'(1))) begin
                    n_state = r_neg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN: begin
                if (slot_free) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (slot_free && r_ndig == DIGCNT_W'(1)) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and output register
    always_comb begin
        n_bin   = r_bin;
        n_bcd   = r_bcd;
        n_cnt   = r_cnt;
        n_ndig  = r_ndig;
        n_neg   = r_neg;
        n_valid = r_valid && !i_ready;
        n_char  = r_char;
        n_last  = r_last;
        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_neg = i_value[VALUE_W-1];
                    n_bin = i_value[VALUE_W-1] ? (VALUE_W'(0) - i_value) : i_value;
                    n_bcd = '0;
                    n_cnt = '0;
                end
            end
            ST_CONV: begin
                n_bcd  = {bcd_adj[BCD_W-2:0], r_bin[VALUE_W-1]};
                n_bin  = {r_bin[VALUE_W-2:0], 1'b0};
                n_cnt  = r_cnt + BITCNT_W'(1);
                n_ndig = DIGCNT_W'(NUM_DIGITS);
            end
            ST_SKIP: begin
                if (top_zero && r_ndig > DIGCNT_W'(1)) begin
                    n_bcd  = {r_bcd[BCD_W-5:0], 4'd0};
                    n_ndig = r_ndig - DIGCNT_W'(1);
                end
            end
            ST_SIGN: begin
                if (slot_free) begin
                    n_valid = 1'b1;
                    n_char  = CHAR_MINUS;
                    n_last  = 1'b0;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    n_valid = 1'b1;
                    n_char  = CHAR_ZERO + {4'd0, r_bcd[BCD_W-1 -: 4]};
                    n_last  = (r_ndig == DIGCNT_W'(1));
                    n_bcd   = {r_bcd[BCD_W-5:0], 4'd0};
                    n_ndig  = r_ndig - DIGCNT_W'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
        r_bin  <= n_bin;
        r_bcd  <= n_bcd;
        r_cnt  <= n_cnt;
        r_ndig <= n_ndig;
        r_neg  <= n_neg;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_ready     = (r_state == ST_IDLE);
    assign o_valid     = r_valid;
    assign o_character = r_char;
    assign o_last      = r_last;

endmodule
